// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the event queue, included by the back end.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/tceq_pkg.sv -----
// Shared types and constants of the timed control event queue.
// Used by the front end, the command queue, the back end and the top level.
package tceq_pkg;

  localparam int FRAME_W       = 48;
  localparam int KIND_W        = 3;
  localparam int VALUE_W       = 32;
  localparam int OSC_W         = 4;
  localparam int STATUS_W      = 3;
  localparam int FRAME_BITS    = 48;
  localparam int OSCILLATORS   = 4;
  localparam int SAMPLE_RATE   = 48000;
  localparam int MAX_RESULTS   = 32;
  localparam int REL_W         = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH   = 2;
  localparam int PENDING_DEPTH = 32;
  localparam int CAPTURE_DEPTH = 256;

  localparam logic [FRAME_W-1:0] FRAME_LIMIT = FRAME_W'((65'd1 << FRAME_BITS) - 65'd1);

  // Q15.16 bounds of the value checks.
  localparam logic signed [63:0] Q_ONE      = 64'sd65536;
  localparam logic signed [63:0] Q_FREQ_MAX = 64'(longint'(SAMPLE_RATE) * 65536 / 2);
  localparam logic signed [63:0] Q_LVL_MAX  = 64'sd7864320;
  localparam logic signed [63:0] Q_LVL_MIN  = -64'sd7864320;
  localparam logic signed [63:0] Q_PEAK_MAX = 64'sd3932160;
  localparam logic signed [63:0] Q_RATE_MIN = 64'sd66;
  localparam logic signed [63:0] Q_RATE_MAX = 64'sd65536000;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CW_ENABLE, KIND_CW_FREQ, KIND_CW_LEVEL, KIND_ST_ENABLE,
    KIND_ST_RATE, KIND_ST_PEAK, KIND_FADE, KIND_INVALID
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK, ST_NOT_CFG, ST_INVALID, ST_LATE, ST_PEND_FULL, ST_CAP_FULL
  } status_t;

  // One classified command handed from the front end to the back end.
  typedef struct packed {
    logic                      is_tick;
    logic                      not_cfg;
    logic                      bad;
    logic [FRAME_W-1:0]        frame;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [FRAME_W-1:0]        length;
    logic [OSC_W-1:0]          osc;
  } cmd_t;

  // One entry of the capture store.
  typedef struct packed {
    logic [FRAME_W-1:0]        frame;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [FRAME_W-1:0]        length;
    logic [OSC_W-1:0]          osc;
  } entry_t;

endpackage

// ----- src/tceq_front.sv -----
// Front end: holds the configured flag, accepts input beats and classifies them.
// Depends on tceq_pkg; feeds tceq_queue.
module tceq_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_write_en,
  input  logic                               cfg_write_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic [tceq_pkg::FRAME_W-1:0]       in_target_frame,
  input  logic [tceq_pkg::KIND_W-1:0]        in_event_kind,
  input  logic signed [tceq_pkg::VALUE_W-1:0] in_event_value,
  input  logic [tceq_pkg::FRAME_W-1:0]       in_fade_length,
  input  logic [tceq_pkg::OSC_W-1:0]         in_osc_index,
  input  logic                               q_full,
  output logic                               q_push,
  output tceq_pkg::cmd_t                     q_cmd
);
  import tceq_pkg::*;

  logic              configured_r;
  logic              cw;
  logic              value_ok;
  logic signed [63:0] v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      configured_r <= 1'b0;
    end else if (cfg_write_en) begin
      configured_r <= cfg_write_data;
    end
  end

  assign v  = {{(64 - VALUE_W){in_event_value[VALUE_W-1]}}, in_event_value};
  assign cw = in_event_kind <= KIND_W'(KIND_CW_LEVEL);

  always_comb begin
    unique case (kind_t'(in_event_kind))
      KIND_CW_ENABLE, KIND_ST_ENABLE: value_ok = (v == 64'sd0) || (v == Q_ONE);
      KIND_CW_FREQ:  value_ok = (v > 64'sd0) && (v < Q_FREQ_MAX);
      KIND_CW_LEVEL: value_ok = (v >= Q_LVL_MIN) && (v <= Q_LVL_MAX);
      KIND_ST_RATE:  value_ok = (v >= Q_RATE_MIN) && (v <= Q_RATE_MAX);
      KIND_ST_PEAK:  value_ok = (v >= Q_LVL_MIN) && (v <= Q_PEAK_MAX);
      KIND_FADE:     value_ok = (v >= 64'sd0) && (v <= Q_LVL_MAX) &&
                                (in_fade_length != '0) &&
                                (in_fade_length <= FRAME_LIMIT - in_target_frame);
      default:       value_ok = 1'b0;
    endcase
  end

  always_comb begin
    q_cmd.is_tick = (in_action == ACT_TICK);
    q_cmd.not_cfg = !configured_r;
    q_cmd.bad     = ((in_event_kind != KIND_W'(KIND_FADE)) && (in_fade_length != '0)) ||
                    (cw && ({1'b0, in_osc_index} >= (OSC_W + 1)'(OSCILLATORS))) ||
                    (!cw && (in_osc_index != '0)) || !value_ok;
    q_cmd.frame   = in_target_frame;
    q_cmd.kind    = in_event_kind;
    q_cmd.value   = in_event_value;
    q_cmd.length  = in_fade_length;
    q_cmd.osc     = in_osc_index;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ----- src/tceq_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on tceq_pkg for the command type.
module tceq_queue #(
  parameter int DEPTH = tceq_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tceq_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output tceq_pkg::cmd_t head_cmd
);
  import tceq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push && !full) - CNT_W'(do_pop);
    end
  end

endmodule

// ----- src/tceq_back.sv -----
// Back end: executes commands, keeps the sorted pending list and the capture store,
// and drives the result register. Depends on tceq_pkg and assert_macros.svh.
module tceq_back #(
  parameter int PENDING_DEPTH = tceq_pkg::PENDING_DEPTH,
  parameter int CAPTURE_DEPTH = tceq_pkg::CAPTURE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_not_empty,
  input  tceq_pkg::cmd_t                      q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_released,
  output logic [tceq_pkg::STATUS_W-1:0]       out_status,
  output logic [tceq_pkg::FRAME_W-1:0]        out_frame,
  output logic [tceq_pkg::KIND_W-1:0]         out_kind,
  output logic signed [tceq_pkg::VALUE_W-1:0] out_value,
  output logic [tceq_pkg::FRAME_W-1:0]        out_length,
  output logic [tceq_pkg::OSC_W-1:0]          out_osc,
  output logic                                out_last
);
  import tceq_pkg::*;
  `include "assert_macros.svh"

  localparam int PC_W = $clog2(PENDING_DEPTH + 1);
  localparam int CC_W = $clog2(CAPTURE_DEPTH + 1);
  localparam int CI_W = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_EMIT, S_REL_CHECK, S_REL_READ, S_REL_EMIT
  } state_t;

  state_t             state_r;
  cmd_t               cmd_r;
  status_t            status_r, st_nxt;
  logic [FRAME_W-1:0] frame_counter_r;
  logic [PC_W-1:0]    pend_count_r;
  logic [CC_W-1:0]    cap_count_r;
  logic [REL_W-1:0]   n_r;
  logic [CI_W-1:0]    rd_addr_r;
  entry_t             rd_data_r;

  logic [FRAME_W-1:0] pend_frame_r [PENDING_DEPTH];
  logic [CI_W-1:0]    pend_idx_r   [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] gt;

  entry_t             mem [CAPTURE_DEPTH];

  logic out_valid_r, out_released_r, out_last_r;
  logic [STATUS_W-1:0] out_status_r;
  entry_t              out_entry_r;

  logic out_free, head_due, more, ins_en, shift_en, emit_now;

  assign out_free = !out_valid_r || !out_stall;
  assign head_due = (pend_count_r != '0) && (pend_frame_r[0] <= frame_counter_r);
  assign more     = head_due && (n_r < REL_W'(MAX_RESULTS));
  assign q_pop    = (state_r == S_IDLE);
  assign ins_en   = (state_r == S_EXEC) && (st_nxt == ST_OK);
  assign shift_en = (state_r == S_REL_CHECK) && head_due;
  assign emit_now = out_free && ((state_r == S_EMIT) || (state_r == S_REL_EMIT));

  always_comb begin
    if (cmd_r.not_cfg) begin
      st_nxt = ST_NOT_CFG;
    end else if (cmd_r.frame < frame_counter_r) begin
      st_nxt = ST_LATE;
    end else if (cmd_r.bad) begin
      st_nxt = ST_INVALID;
    end else if (pend_count_r >= PC_W'(PENDING_DEPTH)) begin
      st_nxt = ST_PEND_FULL;
    end else if (cap_count_r >= CC_W'(CAPTURE_DEPTH)) begin
      st_nxt = ST_CAP_FULL;
    end else begin
      st_nxt = ST_OK;
    end
  end

  // Slots at or past the fill count count as greater, so the new event lands
  // in front of the first later frame, after all equal ones.
  always_comb begin
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      gt[i] = (PC_W'(i) >= pend_count_r) || (pend_frame_r[i] > cmd_r.frame);
    end
  end

  for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (ins_en && gt[i]) begin
        if (i != 0 && gt[(i == 0) ? 0 : i - 1]) begin
          pend_frame_r[i] <= pend_frame_r[(i == 0) ? 0 : i - 1];
          pend_idx_r[i]   <= pend_idx_r[(i == 0) ? 0 : i - 1];
        end else begin
          pend_frame_r[i] <= cmd_r.frame;
          pend_idx_r[i]   <= cap_count_r[CI_W-1:0];
        end
      end else if (shift_en && i < PENDING_DEPTH - 1) begin
        pend_frame_r[i] <= pend_frame_r[(i < PENDING_DEPTH - 1) ? i + 1 : i];
        pend_idx_r[i]   <= pend_idx_r[(i < PENDING_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en) begin
      mem[cap_count_r[CI_W-1:0]] <= '{frame: cmd_r.frame, kind: cmd_r.kind,
                                     value: cmd_r.value, length: cmd_r.length,
                                     osc: cmd_r.osc};
    end
    rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      frame_counter_r <= '0;
      pend_count_r    <= '0;
      cap_count_r     <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            cmd_r    <= q_head;
            n_r      <= '0;
            status_r <= ST_NOT_CFG;
            if (!q_head.is_tick) begin
              state_r <= S_EXEC;
            end else if (q_head.not_cfg) begin
              state_r <= S_EMIT;
            end else begin
              state_r <= S_REL_CHECK;
            end
          end
        end
        S_EXEC: begin
          status_r <= st_nxt;
          if (st_nxt == ST_OK) begin
            pend_count_r <= pend_count_r + 1'b1;
            cap_count_r  <= cap_count_r + 1'b1;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_released_r <= 1'b0;
            out_status_r   <= status_r;
            out_entry_r    <= '0;
            out_last_r     <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        S_REL_CHECK: begin
          if (head_due) begin
            rd_addr_r    <= pend_idx_r[0];
            pend_count_r <= pend_count_r - 1'b1;
            n_r          <= n_r + 1'b1;
            state_r      <= S_REL_READ;
          end else begin
            // Nothing due on this tick.
            if (frame_counter_r < FRAME_LIMIT) begin
              frame_counter_r <= frame_counter_r + 1'b1;
            end
            status_r <= ST_OK;
            state_r  <= S_EMIT;
          end
        end
        S_REL_READ: begin
          state_r <= S_REL_EMIT;
        end
        S_REL_EMIT: begin
          if (out_free) begin
            out_released_r <= 1'b1;
            out_status_r   <= ST_OK;
            out_entry_r    <= rd_data_r;
            out_last_r     <= !more;
            if (more) begin
              state_r <= S_REL_CHECK;
            end else begin
              if (frame_counter_r < FRAME_LIMIT) begin
                frame_counter_r <= frame_counter_r + 1'b1;
              end
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_released = out_released_r;
  assign out_status   = out_status_r;
  assign out_frame    = out_entry_r.frame;
  assign out_kind     = out_entry_r.kind;
  assign out_value    = out_entry_r.value;
  assign out_length   = out_entry_r.length;
  assign out_osc      = out_entry_r.osc;
  assign out_last     = out_last_r;

  `ASSERT_CLK(a_pend_bound, pend_count_r <= PC_W'(PENDING_DEPTH), "pending count overflow")
  `ASSERT_CLK(a_cap_mono, cap_count_r >= $past(cap_count_r), "capture count went down")
  `ASSERT_NEVER(a_rel_status, out_valid_r && out_released_r && (|out_status_r), "bad status")

endmodule

// ----- src/timed_control_event_queue.sv -----
// Timed control event queue. Enqueue beats are checked and answered with one
// status beat; accepted events are kept in a capture store and in a pending list
// sorted by frame. A tick beat releases every due event, up to 32, one beat each
// with last on the final one, or one status beat when nothing is due or when not
// configured. The front end classifies beats into a two-entry queue; the back end
// executes them, each released event passing release check, read and emit states,
// the read state covering the registered read port of the capture memory.
// Depends on tceq_pkg, tceq_front, tceq_queue and tceq_back.
module timed_control_event_queue #(
  parameter int PENDING_DEPTH = tceq_pkg::PENDING_DEPTH,
  parameter int CAPTURE_DEPTH = tceq_pkg::CAPTURE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write_en,
  input  logic                                cfg_write_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [tceq_pkg::FRAME_W-1:0]        in_target_frame,
  input  logic [tceq_pkg::KIND_W-1:0]         in_event_kind,
  input  logic signed [tceq_pkg::VALUE_W-1:0] in_event_value,
  input  logic [tceq_pkg::FRAME_W-1:0]        in_fade_length,
  input  logic [tceq_pkg::OSC_W-1:0]          in_osc_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_released,
  output logic [tceq_pkg::STATUS_W-1:0]       out_status,
  output logic [tceq_pkg::FRAME_W-1:0]        out_frame,
  output logic [tceq_pkg::KIND_W-1:0]         out_kind,
  output logic signed [tceq_pkg::VALUE_W-1:0] out_value,
  output logic [tceq_pkg::FRAME_W-1:0]        out_length,
  output logic [tceq_pkg::OSC_W-1:0]          out_osc,
  output logic                                out_last
);
  import tceq_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic q_push, q_full, q_pop, q_not_empty;

  tceq_front u_front (
    .clk, .rst_n, .cfg_write_en, .cfg_write_data,
    .in_valid, .in_stall, .in_action, .in_target_frame, .in_event_kind,
    .in_event_value, .in_fade_length, .in_osc_index,
    .q_full, .q_push, .q_cmd(push_cmd)
  );

  tceq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(q_push), .push_cmd, .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .head_cmd
  );

  tceq_back #(.PENDING_DEPTH(PENDING_DEPTH), .CAPTURE_DEPTH(CAPTURE_DEPTH)) u_back (
    .clk, .rst_n, .q_not_empty, .q_head(head_cmd), .q_pop,
    .out_valid, .out_stall, .out_released, .out_status, .out_frame, .out_kind,
    .out_value, .out_length, .out_osc, .out_last
  );

endmodule
